### sv/assert_macros.svh
// Assertion macros for the core's RTL; only c8080_exec includes them.
// No dependencies; each macro compiles to nothing when ASSERT_OFF is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg)
`endif
`endif

### sv/c8080_pkg.sv
// Package for the 8080 subset core: widths, flag positions, opcodes and the queue entry type.
// No dependencies.
package c8080_pkg;
  localparam int MemAddrBitsDefault = 16;
  localparam int FZ = 0;
  localparam int FS = 1;
  localparam int FP = 2;
  localparam int FCY = 3;
  localparam int FAC = 4;
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EXEC = 1'b1;
  localparam logic [15:0] RstVector = 16'h0038;

  // Opcodes of the implemented subset, plus HLT, which the core does not implement.
  typedef enum logic [7:0] {
    OP_NOP = 8'h00, OP_LXI_B = 8'h01, OP_STAX_B = 8'h02, OP_INX_B = 8'h03,
    OP_INR_B = 8'h04, OP_DCR_B = 8'h05, OP_MVI_B = 8'h06, OP_DAD_B = 8'h09,
    OP_LDAX_B = 8'h0a, OP_DCX_B = 8'h0b, OP_DCR_C = 8'h0d, OP_MVI_C = 8'h0e,
    OP_RRC = 8'h0f, OP_LXI_D = 8'h11, OP_INX_D = 8'h13, OP_INR_D = 8'h14,
    OP_DAD_D = 8'h19, OP_LDAX_D = 8'h1a, OP_RAR = 8'h1f, OP_LXI_H = 8'h21,
    OP_INX_H = 8'h23, OP_MVI_H = 8'h26, OP_DAD_H = 8'h29, OP_CMA = 8'h2f,
    OP_LXI_SP = 8'h31, OP_STA = 8'h32, OP_MVI_M = 8'h36, OP_LDA = 8'h3a,
    OP_MVI_A = 8'h3e, OP_MOV_BB = 8'h40, OP_MOV_BC = 8'h41, OP_MOV_BD = 8'h42,
    OP_MOV_BE = 8'h43, OP_MOV_DM = 8'h56, OP_MOV_EM = 8'h5e, OP_MOV_HM = 8'h66,
    OP_MOV_LA = 8'h6f, OP_HLT = 8'h76, OP_MOV_MA = 8'h77, OP_MOV_AD = 8'h7a,
    OP_MOV_AE = 8'h7b, OP_MOV_AH = 8'h7c, OP_MOV_AM = 8'h7e, OP_ADD_B = 8'h80,
    OP_ADD_C = 8'h81, OP_ADD_M = 8'h86, OP_ANA_A = 8'ha7, OP_XRA_A = 8'haf,
    OP_POP_B = 8'hc1, OP_JNZ = 8'hc2, OP_JMP = 8'hc3, OP_PUSH_B = 8'hc5,
    OP_ADI = 8'hc6, OP_RET = 8'hc9, OP_CALL = 8'hcd, OP_POP_D = 8'hd1,
    OP_OUT = 8'hd3, OP_PUSH_D = 8'hd5, OP_POP_H = 8'he1, OP_PUSH_H = 8'he5,
    OP_ANI = 8'he6, OP_XCHG = 8'heb, OP_POP_PSW = 8'hf1, OP_DI = 8'hf3,
    OP_PUSH_PSW = 8'hf5, OP_EI = 8'hfb, OP_CPI = 8'hfe, OP_RST7 = 8'hff
  } opcode_t;

  // One classified transaction handed from the front end to the execution unit.
  typedef struct packed {
    logic        exec;
    logic [15:0] addr;
    logic [7:0]  data;
  } c8080_cmd_t;

  // Architectural state as reported in one result.
  typedef struct packed {
    logic        fault;
    logic [7:0]  port_data;
    logic [7:0]  port_number;
    logic        port_write;
    logic        ints_enabled;
    logic [4:0]  flag_bits;
    logic [15:0] pair_hl;
    logic [15:0] pair_de;
    logic [15:0] pair_bc;
    logic [7:0]  accum;
    logic [15:0] stack_ptr;
    logic [15:0] prog_counter;
  } c8080_res_t;

  function automatic logic even_par(input logic [7:0] v);
    return ~^v;
  endfunction
endpackage

### sv/c8080_front.sv
// Front end: accepts input transactions, classifies them and queues them.
// Depends on c8080_pkg.
module c8080_front import c8080_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic       in_tuser,    // operation
  input  logic [23:0] in_tdata,   // address[15:0], data[23:16]
  output logic       q_valid,
  input  logic       q_ready,
  output c8080_cmd_t q_cmd
);
  localparam int Depth = 2;
  c8080_cmd_t  mem_r [Depth];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;
  logic        push, pop;

  assign in_tready = (cnt_r != 2'(Depth));
  assign push = in_tvalid && in_tready;
  assign q_valid = (cnt_r != 2'd0);
  assign pop = q_valid && q_ready;
  assign q_cmd = mem_r[rp_r];

  // Two-entry queue; the payload entries need no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= '{exec: in_tuser, addr: in_tdata[15:0], data: in_tdata[23:16]};
    end
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end
endmodule

### sv/c8080_exec.sv
// Execution unit: fetches and runs one instruction through a single memory port.
// Depends on c8080_pkg and assert_macros.svh.
`include "assert_macros.svh"
module c8080_exec import c8080_pkg::*; #(
  parameter int MEM_ADDR_BITS = MemAddrBitsDefault
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  output logic       q_ready,
  input  c8080_cmd_t q_cmd,
  output logic       out_tvalid,
  input  logic       out_tready,
  output c8080_res_t res
);
  localparam int MemDepth = 1 << MEM_ADDR_BITS;

  typedef enum logic [2:0] {
    S_IDLE, S_F0, S_F1, S_F2, S_DAT, S_RD2, S_WB, S_OUT
  } state_t;

  logic [7:0] mem [MemDepth];
  logic [7:0] rdata_r;
  logic [MEM_ADDR_BITS-1:0] raddr;
  logic       wen;
  logic [MEM_ADDR_BITS-1:0] waddr;
  logic [7:0] wdata;

  state_t      state_r;
  logic [7:0]  a_r, b_r, c_r, d_r, e_r, h_r, l_r;
  logic [15:0] sp_r, pc_r;
  logic [4:0]  f_r;
  logic        ie_r, halt_r;
  logic [7:0]  op_r, b1_r, b2_r, lo_r;
  logic        pw_r;
  logic [7:0]  pn_r, pd_r;
  logic        out_v_r;

  // Memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wen) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  wire [15:0] bc = {b_r, c_r};
  wire [15:0] de = {d_r, e_r};
  wire [15:0] hl = {h_r, l_r};
  wire [15:0] imm = {b2_r, b1_r};
  wire [15:0] imm_n = {rdata_r, b1_r};

  // Instruction class helpers.
  logic two_byte, three_byte, mem_rd, is_pop, push_op, known;
  logic [15:0] rd_addr;
  logic [15:0] push_val;
  always_comb begin
    two_byte = 1'b0; three_byte = 1'b0; mem_rd = 1'b0; is_pop = 1'b0;
    push_op = 1'b0; known = 1'b1; rd_addr = hl; push_val = bc;
    unique case (op_r) inside
      OP_MVI_B, OP_MVI_C, OP_MVI_H, OP_MVI_M, OP_MVI_A, OP_ADI, OP_OUT, OP_ANI,
      OP_CPI: two_byte = 1'b1;
      OP_LXI_B, OP_LXI_D, OP_LXI_H, OP_LXI_SP, OP_STA, OP_JNZ, OP_JMP,
      OP_CALL: three_byte = 1'b1;
      OP_LDA: begin three_byte = 1'b1; mem_rd = 1'b1; rd_addr = imm; end
      OP_LDAX_B: begin mem_rd = 1'b1; rd_addr = bc; end
      OP_LDAX_D: begin mem_rd = 1'b1; rd_addr = de; end
      OP_MOV_DM, OP_MOV_EM, OP_MOV_HM, OP_MOV_AM, OP_ADD_M: mem_rd = 1'b1;
      OP_POP_B, OP_RET, OP_POP_D, OP_POP_H, OP_POP_PSW: begin
        mem_rd = 1'b1; is_pop = 1'b1; rd_addr = sp_r;
      end
      OP_PUSH_B: push_op = 1'b1;
      OP_PUSH_D: begin push_op = 1'b1; push_val = de; end
      OP_PUSH_H: begin push_op = 1'b1; push_val = hl; end
      OP_PUSH_PSW: begin push_op = 1'b1; push_val = {a_r, 3'b000, f_r}; end
      OP_NOP, OP_STAX_B, OP_INX_B, OP_INR_B, OP_DCR_B, OP_DAD_B, OP_DCX_B, OP_DCR_C,
      OP_RRC, OP_INX_D, OP_INR_D, OP_DAD_D, OP_RAR, OP_INX_H, OP_DAD_H, OP_CMA,
      OP_MOV_BB, OP_MOV_BC, OP_MOV_BD, OP_MOV_BE, OP_MOV_LA, OP_MOV_MA, OP_MOV_AD,
      OP_MOV_AE, OP_MOV_AH, OP_ADD_B, OP_ADD_C, OP_ANA_A, OP_XRA_A, OP_XCHG, OP_DI,
      OP_EI, OP_RST7: ;
      default: known = 1'b0;
    endcase
  end

  // Memory port control for the current step.
  always_comb begin
    raddr = q_cmd.addr[MEM_ADDR_BITS-1:0];
    wen = 1'b0;
    waddr = q_cmd.addr[MEM_ADDR_BITS-1:0];
    wdata = q_cmd.data;
    unique case (state_r)
      S_IDLE: raddr = pc_r[MEM_ADDR_BITS-1:0];
      S_F0: raddr = MEM_ADDR_BITS'(pc_r + 16'd1);
      S_F1: raddr = MEM_ADDR_BITS'(pc_r + 16'd2);
      S_F2: raddr = rd_addr[MEM_ADDR_BITS-1:0];
      S_DAT: raddr = MEM_ADDR_BITS'(sp_r + 16'd1);
      default: raddr = rd_addr[MEM_ADDR_BITS-1:0];
    endcase
    if (state_r == S_IDLE && q_valid && !out_v_r && q_cmd.exec == OP_LOAD) wen = 1'b1;
    if (state_r == S_F2) begin
      case (op_r)
        OP_STAX_B: begin wen = 1'b1; waddr = bc[MEM_ADDR_BITS-1:0]; wdata = a_r; end
        OP_STA: begin wen = 1'b1; waddr = imm_n[MEM_ADDR_BITS-1:0]; wdata = a_r; end
        OP_MVI_M: begin wen = 1'b1; waddr = hl[MEM_ADDR_BITS-1:0]; wdata = b1_r; end
        OP_MOV_MA: begin wen = 1'b1; waddr = hl[MEM_ADDR_BITS-1:0]; wdata = a_r; end
        default: ;
      endcase
      if (push_op || op_r == OP_CALL || op_r == OP_RST7) begin
        wen = 1'b1;
        waddr = MEM_ADDR_BITS'(sp_r - 16'd1);
        wdata = (op_r == OP_CALL) ? 8'(pc_r + 16'd3 >> 8) :
                (op_r == OP_RST7) ? 8'(pc_r + 16'd1 >> 8) : push_val[15:8];
      end
    end else if (state_r == S_DAT && !mem_rd) begin
      wen = 1'b1;
      waddr = MEM_ADDR_BITS'(sp_r - 16'd2);
      wdata = (op_r == OP_CALL) ? 8'(pc_r + 16'd3) :
              (op_r == OP_RST7) ? 8'(pc_r + 16'd1) : push_val[7:0];
    end
  end

  assign q_ready = (state_r == S_IDLE) && !out_v_r;

  // ALU helpers for the write-back step.
  logic [7:0] mval;
  logic [8:0] addsum;
  logic [16:0] dadsum;
  logic [7:0] addend, cmpd;
  always_comb begin
    mval = rdata_r;
    addend = (op_r == OP_ADD_B) ? b_r : (op_r == OP_ADD_C) ? c_r :
             (op_r == OP_ADI) ? b1_r : mval;
    addsum = {1'b0, a_r} + {1'b0, addend};
    dadsum = {1'b0, hl} + {1'b0, (op_r == OP_DAD_B) ? bc : (op_r == OP_DAD_D) ? de : hl};
    cmpd = a_r - b1_r;
  end

  // Jump target selection; a taken jump replaces the sequential pc.
  logic        pc_jump;
  logic [15:0] pc_tgt;
  always_comb begin
    pc_jump = 1'b1;
    pc_tgt = imm;
    case (op_r) inside
      OP_JNZ: pc_jump = !f_r[FZ];
      OP_JMP, OP_CALL: ;
      OP_RET: pc_tgt = {rdata_r, lo_r};
      OP_RST7: pc_tgt = RstVector;
      default: pc_jump = 1'b0;
    endcase
  end

  function automatic logic [4:0] zsp(input logic [4:0] f, input logic [7:0] v);
    logic [4:0] g;
    g = f;
    g[FZ] = (v == 8'd0);
    g[FS] = v[7];
    g[FP] = even_par(v);
    return g;
  endfunction

  // Sequencer: fetch, optional data access, write back, then hold the result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      a_r <= '0; b_r <= '0; c_r <= '0; d_r <= '0; e_r <= '0; h_r <= '0; l_r <= '0;
      sp_r <= '0; pc_r <= '0; f_r <= '0; ie_r <= 1'b0; halt_r <= 1'b0;
      out_v_r <= 1'b0; pw_r <= 1'b0; pn_r <= '0; pd_r <= '0;
    end else begin
      if (out_v_r && out_tready) out_v_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (q_valid && !out_v_r) begin
            pw_r <= 1'b0; pn_r <= '0; pd_r <= '0;
            if (q_cmd.exec == OP_EXEC && !halt_r) state_r <= S_F0;
            else out_v_r <= 1'b1;
          end
        end
        S_F0: begin op_r <= rdata_r; state_r <= S_F1; end
        S_F1: begin b1_r <= rdata_r; state_r <= S_F2; end
        S_F2: begin
          b2_r <= rdata_r;
          if (!known) begin
            halt_r <= 1'b1;
            state_r <= S_OUT;
          end else if (mem_rd && op_r == OP_LDA) begin
            state_r <= S_RD2;
          end else if (mem_rd || push_op || op_r == OP_CALL || op_r == OP_RST7) begin
            state_r <= S_DAT;
          end else begin
            state_r <= S_WB;
          end
        end
        S_RD2: state_r <= S_DAT;
        S_DAT: begin lo_r <= rdata_r; state_r <= S_WB; end
        S_WB: begin
          pc_r <= pc_jump ? pc_tgt :
                  pc_r + (three_byte ? 16'd3 : two_byte ? 16'd2 : 16'd1);
          if (is_pop) sp_r <= sp_r + 16'd2;
          if (push_op) sp_r <= sp_r - 16'd2;
          case (op_r) inside
            OP_LXI_B: {b_r, c_r} <= imm;
            OP_INX_B: {b_r, c_r} <= bc + 16'd1;
            OP_INR_B: begin b_r <= b_r + 8'd1; f_r <= zsp(f_r, b_r + 8'd1); end
            OP_DCR_B: begin b_r <= b_r - 8'd1; f_r <= zsp(f_r, b_r - 8'd1); end
            OP_MVI_B: b_r <= b1_r;
            OP_DAD_B, OP_DAD_D, OP_DAD_H: begin
              {h_r, l_r} <= dadsum[15:0]; f_r[FCY] <= dadsum[16];
            end
            OP_LDAX_B, OP_LDAX_D, OP_LDA, OP_MOV_AM: a_r <= lo_r;
            OP_DCX_B: {b_r, c_r} <= bc - 16'd1;
            OP_DCR_C: begin c_r <= c_r - 8'd1; f_r <= zsp(f_r, c_r - 8'd1); end
            OP_MVI_C: c_r <= b1_r;
            OP_RRC: begin f_r[FCY] <= a_r[0]; a_r <= {a_r[0], a_r[7:1]}; end
            OP_LXI_D: {d_r, e_r} <= imm;
            OP_INX_D: {d_r, e_r} <= de + 16'd1;
            OP_INR_D: begin d_r <= d_r + 8'd1; f_r <= zsp(f_r, d_r + 8'd1); end
            OP_RAR: begin f_r[FCY] <= a_r[0]; a_r <= {f_r[FCY], a_r[7:1]}; end
            OP_LXI_H: {h_r, l_r} <= imm;
            OP_INX_H: {h_r, l_r} <= hl + 16'd1;
            OP_MVI_H: h_r <= b1_r;
            OP_CMA: a_r <= ~a_r;
            OP_LXI_SP: sp_r <= imm;
            OP_MVI_A: a_r <= b1_r;
            OP_MOV_BC: b_r <= c_r;
            OP_MOV_BD: b_r <= d_r;
            OP_MOV_BE: b_r <= e_r;
            OP_MOV_DM: d_r <= lo_r;
            OP_MOV_EM: e_r <= lo_r;
            OP_MOV_HM: h_r <= lo_r;
            OP_MOV_LA: l_r <= a_r;
            OP_MOV_AD: a_r <= d_r;
            OP_MOV_AE: a_r <= e_r;
            OP_MOV_AH: a_r <= h_r;
            OP_ADD_B, OP_ADD_C, OP_ADI: begin
              a_r <= addsum[7:0];
              f_r <= zsp({f_r[FAC], addsum[8], f_r[2:0]}, addsum[7:0]);
            end
            OP_ADD_M: begin
              a_r <= 8'(a_r + lo_r);
              f_r <= zsp({f_r[FAC], (9'(a_r) + 9'(lo_r)) > 9'd255, f_r[2:0]}, 8'(a_r + lo_r));
            end
            OP_ANA_A: f_r <= zsp({1'b0, 1'b0, f_r[2:0]}, a_r);
            OP_XRA_A: begin a_r <= '0; f_r <= zsp(5'd0, 8'd0); end
            OP_POP_B: {b_r, c_r} <= {rdata_r, lo_r};
            OP_CALL: sp_r <= sp_r - 16'd2;
            OP_POP_D: {d_r, e_r} <= {rdata_r, lo_r};
            OP_OUT: begin pw_r <= 1'b1; pn_r <= b1_r; pd_r <= a_r; end
            OP_POP_H: {h_r, l_r} <= {rdata_r, lo_r};
            OP_ANI: begin a_r <= a_r & b1_r; f_r <= zsp(5'd0, a_r & b1_r); end
            OP_XCHG: begin {d_r, e_r} <= hl; {h_r, l_r} <= de; end
            OP_POP_PSW: begin f_r <= lo_r[4:0]; a_r <= rdata_r; end
            OP_DI: ie_r <= 1'b0;
            OP_EI: ie_r <= 1'b1;
            OP_CPI: f_r <= zsp({f_r[FAC], a_r < b1_r, f_r[2:0]}, cmpd);
            OP_RST7: sp_r <= sp_r - 16'd2;
            default: ;
          endcase
          state_r <= S_OUT;
        end
        S_OUT: begin out_v_r <= 1'b1; state_r <= S_IDLE; end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_v_r;
  assign res = '{fault: halt_r, port_data: pd_r, port_number: pn_r, port_write: pw_r,
                 ints_enabled: ie_r, flag_bits: f_r, pair_hl: hl, pair_de: de,
                 pair_bc: bc, accum: a_r, stack_ptr: sp_r, prog_counter: pc_r};

  `ASSERT_CLK(a_pw_no_fault, clk, rst_n, out_tvalid |-> !(res.port_write && res.fault), "OUT with fault")
  `ASSERT_CLK(a_halt_sticky, clk, rst_n, $past(halt_r) |-> halt_r, "halt cleared")
  `ASSERT_CLK(a_busy_no_take, clk, rst_n, (state_r != S_IDLE) |-> !q_ready, "take while busy")
endmodule

### sv/cpu8080_subset_core.sv
// Top level of the 8080 subset core: front-end queue plus execution unit.
// Depends on c8080_pkg, c8080_front and c8080_exec.
//
// A load answers straight from the idle state, and so does an execute while the
// core is halted. An executed instruction steps through three instruction-byte
// reads, a write-back and a result step, all through the single memory port. A data
// read, a pop or a push adds a data step, LDA adds a second read step before it, and
// an unimplemented opcode goes from the reads straight to the result step. The core
// works on one transaction at a time and takes the next one from its two-entry input
// queue the cycle after the result is accepted. Each transaction returns one result.
module cpu8080_subset_core import c8080_pkg::*; #(
  parameter int MEM_ADDR_BITS = MemAddrBitsDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic        in_tuser,   // operation
  input  logic [23:0] in_tdata,   // address[15:0], data[23:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [111:0] out_tdata  // prog_counter, stack_ptr, accum, pair_bc, pair_de,
                                  // pair_hl, flag_bits, ints_enabled, port_write,
                                  // port_number, port_data, fault
);
  logic       q_valid, q_ready;
  c8080_cmd_t q_cmd;
  c8080_res_t res;

  c8080_front u_front (.clk, .rst_n, .in_tvalid, .in_tready, .in_tuser, .in_tdata,
                       .q_valid, .q_ready, .q_cmd);
  c8080_exec #(.MEM_ADDR_BITS(MEM_ADDR_BITS)) u_exec (.clk, .rst_n, .q_valid, .q_ready,
                       .q_cmd, .out_tvalid, .out_tready, .res);

  assign out_tdata = res;
endmodule

### dv/tb_cpu8080_subset_core.sv
// Self-checking testbench for cpu8080_subset_core: random instruction streams with a
// built-in instruction-level predictor and an in-order result scoreboard.
// Depends on c8080_pkg and the cpu8080_subset_core RTL.
module tb_cpu8080_subset_core;
  import c8080_pkg::*;

  // Architectural model of the core plus the queue of results it still owes.
  class cpu_scoreboard;
    logic [7:0]  mem [65536];
    bit          written [65536];
    logic [7:0]  a, b, c, d, e, h, l;
    logic [15:0] sp, pc;
    logic [4:0]  fl;
    logic        ie, halted;
    c8080_res_t  owed_q[$];
    int          errors, n_exec, n_load, n_out;

    function void wr_byte(logic [15:0] adr, logic [7:0] v);
      mem[adr] = v;
      written[adr] = 1'b1;
    endfunction

    function void set_zsp(logic [7:0] v);
      fl[FZ] = (v == 8'd0);
      fl[FS] = v[7];
      fl[FP] = ~^v;
    endfunction

    function logic [7:0] step_reg(logic [7:0] v, bit up);
      logic [7:0] r;
      r = up ? v + 8'd1 : v - 8'd1;
      set_zsp(r);
      return r;
    endfunction

    function void add_a(logic [7:0] v);
      logic [8:0] s;
      s = {1'b0, a} + {1'b0, v};
      a = s[7:0];
      set_zsp(a);
      fl[FCY] = s[8];
    endfunction

    function void logic_done();
      set_zsp(a);
      fl[FCY] = 1'b0;
      fl[FAC] = 1'b0;
    endfunction

    function void dad(logic [15:0] v);
      logic [16:0] s;
      s = {1'b0, h, l} + {1'b0, v};
      {h, l} = s[15:0];
      fl[FCY] = s[16];
    endfunction

    function void push_word(logic [15:0] v);
      wr_byte(sp - 16'd1, v[15:8]);
      wr_byte(sp - 16'd2, v[7:0]);
      sp = sp - 16'd2;
    endfunction

    function logic [15:0] pop_word();
      logic [15:0] v;
      v = {mem[sp + 16'd1], mem[sp]};
      sp = sp + 16'd2;
      return v;
    endfunction

    // Applies one accepted transaction and queues the state the core must report.
    function void note_input(logic op, logic [15:0] adr, logic [7:0] v);
      logic [7:0]  opc, b1, b2;
      logic [15:0] imm, hl, de, len;
      c8080_res_t  r;
      r = '0;
      if (op == OP_LOAD) begin
        wr_byte(adr, v);
        n_load++;
      end else if (!halted) begin
        n_exec++;
        opc = mem[pc];
        b1 = mem[pc + 16'd1];
        b2 = mem[pc + 16'd2];
        imm = {b2, b1};
        hl = {h, l};
        len = 16'd1;
        case (opc) inside
          OP_NOP, OP_MOV_BB: ;
          OP_LXI_B: begin {b, c} = imm; len = 16'd3; end
          OP_STAX_B: wr_byte({b, c}, a);
          OP_INX_B: {b, c} = {b, c} + 16'd1;
          OP_INR_B: b = step_reg(b, 1);
          OP_DCR_B: b = step_reg(b, 0);
          OP_MVI_B: begin b = b1; len = 16'd2; end
          OP_DAD_B: dad({b, c});
          OP_LDAX_B: a = mem[{b, c}];
          OP_DCX_B: {b, c} = {b, c} - 16'd1;
          OP_DCR_C: c = step_reg(c, 0);
          OP_MVI_C: begin c = b1; len = 16'd2; end
          OP_RRC: begin fl[FCY] = a[0]; a = {a[0], a[7:1]}; end
          OP_LXI_D: begin {d, e} = imm; len = 16'd3; end
          OP_INX_D: {d, e} = {d, e} + 16'd1;
          OP_INR_D: d = step_reg(d, 1);
          OP_DAD_D: dad({d, e});
          OP_LDAX_D: a = mem[{d, e}];
          OP_RAR: begin
            b1 = {fl[FCY], a[7:1]};
            fl[FCY] = a[0];
            a = b1;
          end
          OP_LXI_H: begin {h, l} = imm; len = 16'd3; end
          OP_INX_H: {h, l} = hl + 16'd1;
          OP_MVI_H: begin h = b1; len = 16'd2; end
          OP_DAD_H: dad(hl);
          OP_CMA: a = ~a;
          OP_LXI_SP: begin sp = imm; len = 16'd3; end
          OP_STA: begin wr_byte(imm, a); len = 16'd3; end
          OP_MVI_M: begin wr_byte(hl, b1); len = 16'd2; end
          OP_LDA: begin a = mem[imm]; len = 16'd3; end
          OP_MVI_A: begin a = b1; len = 16'd2; end
          OP_MOV_BC: b = c;
          OP_MOV_BD: b = d;
          OP_MOV_BE: b = e;
          OP_MOV_DM: d = mem[hl];
          OP_MOV_EM: e = mem[hl];
          OP_MOV_HM: h = mem[hl];
          OP_MOV_LA: l = a;
          OP_MOV_MA: wr_byte(hl, a);
          OP_MOV_AD: a = d;
          OP_MOV_AE: a = e;
          OP_MOV_AH: a = h;
          OP_MOV_AM: a = mem[hl];
          OP_ADD_B: add_a(b);
          OP_ADD_C: add_a(c);
          OP_ADD_M: add_a(mem[hl]);
          OP_ANA_A: logic_done();
          OP_XRA_A: begin a = 8'd0; logic_done(); end
          OP_POP_B: {b, c} = pop_word();
          OP_JNZ: begin
            if (!fl[FZ]) begin pc = imm; len = 16'd0; end
            else len = 16'd3;
          end
          OP_JMP: begin pc = imm; len = 16'd0; end
          OP_PUSH_B: push_word({b, c});
          OP_ADI: begin add_a(b1); len = 16'd2; end
          OP_RET: begin pc = pop_word(); len = 16'd0; end
          OP_CALL: begin push_word(pc + 16'd3); pc = imm; len = 16'd0; end
          OP_POP_D: {d, e} = pop_word();
          OP_OUT: begin
            r.port_write = 1'b1;
            r.port_number = b1;
            r.port_data = a;
            len = 16'd2;
          end
          OP_PUSH_D: push_word({d, e});
          OP_POP_H: {h, l} = pop_word();
          OP_PUSH_H: push_word(hl);
          OP_ANI: begin a = a & b1; logic_done(); len = 16'd2; end
          OP_XCHG: begin
            de = {d, e};
            {d, e} = hl;
            {h, l} = de;
          end
          OP_POP_PSW: begin
            imm = pop_word();
            fl = imm[4:0];
            a = imm[15:8];
          end
          OP_DI: ie = 1'b0;
          OP_PUSH_PSW: push_word({a, 3'd0, fl});
          OP_EI: ie = 1'b1;
          OP_CPI: begin
            set_zsp(a - b1);
            fl[FCY] = (a < b1);
            len = 16'd2;
          end
          OP_RST7: begin push_word(pc + 16'd1); pc = RstVector; len = 16'd0; end
          default: begin halted = 1'b1; len = 16'd0; end
        endcase
        if (len != 16'd0) pc = pc + len;
        if (r.port_write) n_out++;
      end
      r.prog_counter = pc;
      r.stack_ptr = sp;
      r.accum = a;
      r.pair_bc = {b, c};
      r.pair_de = {d, e};
      r.pair_hl = {h, l};
      r.flag_bits = fl;
      r.ints_enabled = ie;
      r.fault = halted;
      owed_q.push_back(r);
    endfunction

    function void cmp(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    // Compares one accepted result with the oldest owed state.
    function void check(logic [111:0] raw);
      c8080_res_t got, want;
      got = raw;
      if (owed_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, raw);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      cmp("prog_counter", want.prog_counter, got.prog_counter);
      cmp("stack_ptr", want.stack_ptr, got.stack_ptr);
      cmp("accum", want.accum, got.accum);
      cmp("pair_bc", want.pair_bc, got.pair_bc);
      cmp("pair_de", want.pair_de, got.pair_de);
      cmp("pair_hl", want.pair_hl, got.pair_hl);
      cmp("flag_bits", want.flag_bits, got.flag_bits);
      cmp("ints_enabled", want.ints_enabled, got.ints_enabled);
      cmp("port_write", want.port_write, got.port_write);
      cmp("port_number", want.port_number, got.port_number);
      cmp("port_data", want.port_data, got.port_data);
      cmp("fault", want.fault, got.fault);
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic         in_tuser = 1'b0;  // operation
  logic [23:0]  in_tdata = '0;    // address[15:0], data[23:16]
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [111:0] out_tdata;        // prog_counter, stack_ptr, accum, pair_bc, pair_de,
                                  // pair_hl, flag_bits, ints_enabled, port_write,
                                  // port_number, port_data, fault

  cpu_scoreboard sb = new();
  int snd_idle = 0;
  int rcv_idle = 0;
  int hold_left = 0;
  int items = 0;
  opcode_t valid_ops[$];

  cpu8080_subset_core dut (.*);

  initial forever #1 clk = ~clk;

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

  // Result side: random back-pressure, a long hold-off on request, and checking.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check(out_tdata);
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  // Offers one transaction and records it in the model once it is accepted.
  task automatic send_item(logic op, logic [15:0] adr, logic [7:0] v);
    while ($urandom_range(99) < snd_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {v, adr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(op, adr, v);
    items++;
  endtask

  // Loads a byte unless memory already holds it.
  task automatic put_byte(logic [15:0] adr, logic [7:0] v);
    if (!sb.written[adr] || sb.mem[adr] !== v) send_item(OP_LOAD, adr, v);
  endtask

  // Makes sure a byte the instruction will read has been written.
  task automatic need_byte(logic [15:0] adr);
    if (!sb.written[adr]) send_item(OP_LOAD, adr, 8'($urandom));
  endtask

  // Places one instruction at pc, primes any memory it reads, and executes it.
  task automatic run_instr(opcode_t opc, logic [7:0] b1, logic [7:0] b2);
    logic [15:0] pc;
    pc = sb.pc;
    case (opc) inside
      OP_LDAX_B: need_byte({sb.b, sb.c});
      OP_LDAX_D: need_byte({sb.d, sb.e});
      OP_MOV_DM, OP_MOV_EM, OP_MOV_HM, OP_MOV_AM, OP_ADD_M: need_byte({sb.h, sb.l});
      OP_LDA: need_byte({b2, b1});
      OP_POP_B, OP_POP_D, OP_POP_H, OP_POP_PSW, OP_RET: begin
        need_byte(sb.sp);
        need_byte(sb.sp + 16'd1);
      end
      default: ;
    endcase
    put_byte(pc, opc);
    put_byte(pc + 16'd1, b1);
    put_byte(pc + 16'd2, b2);
    send_item(OP_EXEC, 16'($urandom), 8'($urandom));
  endtask

  // Stops offering input and waits until every owed result has been taken.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.owed_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    opcode_t o;
    o = o.first();
    forever begin
      if (o != OP_HLT) valid_ops.push_back(o);
      if (o == o.last()) break;
      o = o.next();
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: carries out of 8 and 16 bits, zero results, port write, DI/EI.
    run_instr(OP_MVI_A, 8'hff, 8'h00);
    run_instr(OP_ADI, 8'h01, 8'h00);
    run_instr(OP_LXI_H, 8'hff, 8'hff);
    run_instr(OP_DAD_H, 8'h00, 8'h00);
    run_instr(OP_EI, 8'h00, 8'h00);
    run_instr(OP_CMA, 8'h00, 8'h00);
    run_instr(OP_OUT, 8'hff, 8'h00);
    run_instr(OP_XRA_A, 8'h00, 8'h00);
    run_instr(OP_DI, 8'h00, 8'h00);

    // Random instruction streams with stray loads, over three idling phases.
    for (int ph = 0; ph < 3; ph++) begin
      snd_idle = (ph == 0) ? 31 : (ph == 1) ? 46 : 0;
      rcv_idle = (ph == 0) ? 46 : (ph == 1) ? 31 : 0;
      if (ph == 1) hold_left = 300;
      while (items < (ph + 1) * 470) begin
        if ($urandom_range(99) < 15)
          send_item(OP_LOAD, 16'($urandom), 8'($urandom));
        else
          run_instr(valid_ops[$urandom_range(valid_ops.size() - 1)],
                    8'($urandom), 8'($urandom));
      end
      if (ph == 0) drain();
    end

    // Unimplemented opcode halts the core; execute and load while halted.
    run_instr(OP_HLT, 8'h00, 8'h00);
    send_item(OP_EXEC, 16'hffff, 8'hff);
    send_item(OP_LOAD, 16'h0000, 8'h00);
    drain();
    repeat (20) @(posedge clk);

    $display("Covered %0d transactions: %0d executed instructions, %0d loads, %0d OUTs,",
             items, sb.n_exec, sb.n_load, sb.n_out);
    $display("with back-pressure, a long output stall and a final halt on a bad opcode.");
    if (sb.errors == 0 && sb.owed_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

### sim.f
+incdir+sv
sv/c8080_pkg.sv
sv/c8080_front.sv
sv/c8080_exec.sv
sv/cpu8080_subset_core.sv
dv/tb_cpu8080_subset_core.sv
